// ===== rtl/tcw_pkg.sv =====
// Shared constants, types and a helper function for the text console writer.
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COLX_W    = COL_W + 6;
    localparam int ROWX_W    = ROW_W + 1;
    localparam int TAB_STOPS = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;

    localparam int ROW_FIELD_W    = 5;
    localparam int COL_FIELD_W    = 7;
    localparam int OFFSET_FIELD_W = 11;
    localparam int BYTE_W         = 8;
    localparam int CELL_W         = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'd32;
    localparam logic [BYTE_W-1:0] ATTR_DEFAULT   = 8'h0F;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_COPY  = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_CLEAR = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } tcw_state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [CELL_W-1:0]     wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } tcw_mem_req_t;

    typedef struct packed {
        logic                  valid;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [BYTE_W-1:0]     cell_char;
        logic [BYTE_W-1:0]     cell_attr;
    } tcw_result_t;

    // Smallest multiple of TAB_WIDTH at or above the column
    function automatic logic [COLX_W-1:0] tab_next(input logic [COLX_W-1:0] col);
        logic [COLX_W-1:0] stop;
        logic [COLX_W-1:0] res;
        logic              found;
        res   = col;
        found = 1'b0;
        for (int k = TAB_STOPS; k >= 0; k--)
        begin
            stop = COLX_W'(k * TAB_WIDTH);
            if (stop >= col)
            begin
                res   = stop;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            res = col;
        end
        return res;
    endfunction

endpackage

// ===== rtl/text_console_writer_top.sv =====
// Top level of the text console writer: attribute register, engine, store, result register.
//
// Input channel (in_valid / in_stall): one word per item. kind 0 puts char_code at
// the cursor (newline, tab and backspace act as control codes), kind 1 reads the
// cell at read_row / read_col. Out-of-range reads return zero cell bytes.
// Output channel (out_valid / out_stall): one result word per item with the cursor
// position, its linear offset and the read cell (zero bytes for puts).
// cfg_wr_en / cfg_wr_data write the attribute byte stored with every printed,
// erased or scroll-cleared cell; write it only while the block is idle.
// A put without scroll or an off-screen read passes EXEC and DONE, an on-screen read
// EXEC, READ and DONE. A put that scrolls walks the store once through its read and
// write ports: COPY moves rows 1 to ROWS-1 up by one row, FLUSH writes the last
// copied word and CLEAR fills the bottom row with spaces before DONE. One item is
// in work at a time; in_stall is high until the engine is back at idle.
// Reset: the cursor goes to 0,0, the attribute to 0x0F, and a clearing pass over all
// ROWS*COLUMNS cells (2000) fills the store with spaces while in_stall stays high.
// A stalled result is held in the output register; the engine may take and work a
// further item, then waits with its result, taking no new item, until the held one moves.
module text_console_writer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [tcw_pkg::BYTE_W-1:0]          char_code,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0]     read_col,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcw_pkg::ROW_FIELD_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_FIELD_W-1:0]     cursor_col,
    output logic [tcw_pkg::OFFSET_FIELD_W-1:0]  cursor_offset,
    output logic [tcw_pkg::BYTE_W-1:0]          cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]          cell_attr,
    input  logic                                cfg_wr_en,
    input  logic [tcw_pkg::BYTE_W-1:0]          cfg_wr_data
);
    import tcw_pkg::*;

    logic [BYTE_W-1:0]          attr_reg;
    logic                       out_valid_reg;
    logic [ROW_FIELD_W-1:0]     row_out_reg;
    logic [COL_FIELD_W-1:0]     col_out_reg;
    logic [OFFSET_FIELD_W-1:0]  offset_out_reg;
    logic [BYTE_W-1:0]          char_out_reg;
    logic [BYTE_W-1:0]          attr_out_reg;
    logic [ADDR_W-1:0]          offset;
    logic                       res_ready;
    logic                       load;
    tcw_result_t                res;
    tcw_mem_req_t               mem_req;
    logic [CELL_W-1:0]          mem_rdata;

    tcw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .attr      (attr_reg),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    tcw_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res.valid && res_ready;
    assign offset    = ADDR_W'(res.row) * ADDR_W'(COLUMNS) + ADDR_W'(res.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_out_reg    <= ROW_FIELD_W'(res.row);
            col_out_reg    <= COL_FIELD_W'(res.col);
            offset_out_reg <= OFFSET_FIELD_W'(offset);
            char_out_reg   <= res.cell_char;
            attr_out_reg   <= res.cell_attr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_row    = row_out_reg;
    assign cursor_col    = col_out_reg;
    assign cursor_offset = offset_out_reg;
    assign cell_char     = char_out_reg;
    assign cell_attr     = attr_out_reg;

endmodule

// ===== rtl/tcw_store.sv =====
// Screen cell store: character and attribute byte per cell, one write and one read port.
module tcw_store (
    input  logic                 clk,
    input  tcw_pkg::tcw_mem_req_t req,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcw_engine.sv =====
// Sequencer: cursor update, cell writes, reads, scroll copy and row clearing.
module tcw_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [tcw_pkg::BYTE_W-1:0]   char_code,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0] read_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0] read_col,
    input  logic [tcw_pkg::BYTE_W-1:0]   attr,
    input  logic                         res_ready,
    output tcw_pkg::tcw_result_t         res,
    output tcw_pkg::tcw_mem_req_t        mem_req,
    input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);
    import tcw_pkg::*;

    tcw_state_t                state_reg, state_next;
    logic [ADDR_W-1:0]         cnt_reg, cnt_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic                      pend_reg, pend_next;
    logic [ADDR_W-1:0]         waddr_reg, waddr_next;

    logic                      kind_reg;
    logic [BYTE_W-1:0]         char_reg;
    logic [ROW_FIELD_W-1:0]    rrow_reg;
    logic [COL_FIELD_W-1:0]    rcol_reg;
    logic [BYTE_W-1:0]         cell_char_reg, cell_char_next;
    logic [BYTE_W-1:0]         cell_attr_reg, cell_attr_next;

    logic [COLX_W-1:0]         colx;
    logic [ROWX_W-1:0]         rowx;
    logic [ROW_W-1:0]          wr_row;
    logic [COL_W-1:0]          wr_col;
    logic [BYTE_W-1:0]         wr_char;
    logic                      scroll;
    logic [ADDR_W-1:0]         put_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      rd_in_range;

    // Cursor arithmetic for a put item
    always_comb
    begin
        colx    = COLX_W'(col_reg);
        rowx    = ROWX_W'(row_reg);
        wr_row  = row_reg;
        wr_col  = col_reg;
        wr_char = char_reg;
        scroll  = 1'b0;
        case (char_reg)
            CHAR_NEWLINE:
            begin
                colx = '0;
                rowx = rowx + ROWX_W'(1);
            end
            CHAR_TAB:
            begin
                colx = tab_next(colx);
            end
            CHAR_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    colx = colx - COLX_W'(1);
                end
                else if (row_reg != '0)
                begin
                    rowx = rowx - ROWX_W'(1);
                    colx = COLX_W'(COLUMNS - 1);
                end
                wr_row  = ROW_W'(rowx);
                wr_col  = COL_W'(colx);
                wr_char = CHAR_SPACE;
            end
            default:
            begin
                colx = colx + COLX_W'(1);
            end
        endcase
        if (colx >= COLX_W'(COLUMNS))
        begin
            colx = '0;
            rowx = rowx + ROWX_W'(1);
        end
        if (rowx >= ROWX_W'(ROWS))
        begin
            scroll = 1'b1;
            rowx   = ROWX_W'(ROWS - 1);
            colx   = '0;
        end
    end

    assign put_addr    = ADDR_W'(wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
    assign rd_addr     = ADDR_W'(rrow_reg) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_reg);
    assign rd_in_range = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pend_next      = pend_reg;
        waddr_next     = waddr_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        mem_req        = '0;
        case (state_reg)
            S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = {CHAR_SPACE, ATTR_DEFAULT};
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cell_char_next = '0;
                cell_attr_next = '0;
                if (kind_reg == KIND_PUT)
                begin
                    mem_req.we    = (char_reg != CHAR_NEWLINE) && (char_reg != CHAR_TAB);
                    mem_req.waddr = put_addr;
                    mem_req.wdata = {wr_char, attr};
                    row_next      = ROW_W'(rowx);
                    col_next      = COL_W'(colx);
                    if (scroll)
                    begin
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (rd_in_range)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_addr;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cell_char_next = mem_rdata[CELL_W-1:BYTE_W];
                cell_attr_next = mem_rdata[BYTE_W-1:0];
                state_next     = S_DONE;
            end
            S_COPY:
            begin
                // Read one row ahead, write the word fetched last cycle
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_reg + ADDR_W'(COLUMNS);
                mem_req.we    = pend_reg;
                mem_req.waddr = waddr_reg;
                mem_req.wdata = mem_rdata;
                pend_next     = 1'b1;
                waddr_next    = cnt_reg;
                if (cnt_reg == ADDR_W'(CELLS - COLUMNS - 1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_FLUSH:
            begin
                mem_req.we    = pend_reg;
                mem_req.waddr = waddr_reg;
                mem_req.wdata = mem_rdata;
                pend_next     = 1'b0;
                cnt_next      = ADDR_W'(CELLS - COLUMNS);
                state_next    = S_CLEAR;
            end
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = {CHAR_SPACE, attr};
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            pend_reg  <= 1'b0;
            waddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pend_reg  <= pend_next;
            waddr_reg <= waddr_next;
        end
    end

    // Hold the accepted word and the read cell
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg <= kind;
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign res.valid     = (state_reg == S_DONE);
    assign res.row       = row_reg;
    assign res.col       = col_reg;
    assign res.cell_char = cell_char_reg;
    assign res.cell_attr = cell_attr_reg;

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer and their binding to the top level.
module tcw_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0]     cursor_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0]     cursor_col,
    input  logic [tcw_pkg::OFFSET_FIELD_W-1:0]  cursor_offset,
    input  logic [tcw_pkg::BYTE_W-1:0]          cell_char,
    input  logic [tcw_pkg::BYTE_W-1:0]          cell_attr
);
    import tcw_pkg::*;

    // A stalled result word holds its valid, offset and cell bytes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_offset)
            && $stable(cell_char) && $stable(cell_attr))
        else $error("stalled result word changed");

    // Offset agrees with row and column
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cursor_offset) == int'(cursor_row) * COLUMNS + int'(cursor_col)))
        else $error("cursor offset does not match row and column");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cursor_row) < ROWS) && (int'(cursor_col) < COLUMNS))
        else $error("cursor off the screen");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while an item is in work");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);

// ===== bench/tb_text_console_writer_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the text console writer: shadow screen, directed and random words.
module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 2100;   // longer than one scroll pass
    localparam int LONG_HOLD       = 400;

    typedef struct {
        logic                      kind;
        logic [BYTE_W-1:0]         char_code;
        logic [ROW_FIELD_W-1:0]    read_row;
        logic [COL_FIELD_W-1:0]    read_col;
    } console_word_t;

    typedef struct {
        logic [ROW_FIELD_W-1:0]    row;
        logic [COL_FIELD_W-1:0]    col;
        logic [OFFSET_FIELD_W-1:0] offset;
        logic [BYTE_W-1:0]         ch;
        logic [BYTE_W-1:0]         attr;
    } console_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic                      kind        = KIND_PUT;
    logic [BYTE_W-1:0]         char_code   = '0;
    logic [ROW_FIELD_W-1:0]    read_row    = '0;
    logic [COL_FIELD_W-1:0]    read_col    = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [ROW_FIELD_W-1:0]    cursor_row;
    logic [COL_FIELD_W-1:0]    cursor_col;
    logic [OFFSET_FIELD_W-1:0] cursor_offset;
    logic [BYTE_W-1:0]         cell_char;
    logic [BYTE_W-1:0]         cell_attr;
    logic                      cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0]         cfg_wr_data = '0;

    text_console_writer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .cursor_offset (cursor_offset),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the screen, cursor and attribute
    logic [BYTE_W-1:0] shadow_chars [CELLS];
    logic [BYTE_W-1:0] shadow_attrs [CELLS];
    int                shadow_row;
    int                shadow_col;
    logic [BYTE_W-1:0] shadow_attr;

    console_word_t     words_to_send [$];
    console_result_t   awaited_results [$];
    console_word_t     next_word;
    console_word_t     taken_word;
    console_result_t   want;

    bit sender_gaps_on     = 1'b1;
    bit receiver_stalls_on = 1'b1;
    int send_gap           = 0;
    int hold_left          = 0;
    int stall_len          = 0;
    int holds_asked        = 0;
    int holds_served       = 0;

    int failures        = 0;
    int results_checked = 0;
    int puts_done       = 0;
    int reads_done      = 0;
    int off_screen      = 0;
    int scrolls_done    = 0;
    int wraps_done      = 0;
    int attr_writes     = 0;

    function automatic void shadow_reset();
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_chars[i] = CHAR_SPACE;
            shadow_attrs[i] = ATTR_DEFAULT;
        end
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = ATTR_DEFAULT;
    endfunction

    function automatic void shadow_store(int row, int col, logic [BYTE_W-1:0] ch);
        shadow_chars[row * COLUMNS + col] = ch;
        shadow_attrs[row * COLUMNS + col] = shadow_attr;
    endfunction

    // Work out the cursor and cell after one word, updating the shadow screen
    function automatic console_result_t console_apply(console_word_t w);
        console_result_t r;
        int              row;
        int              col;
        row    = shadow_row;
        col    = shadow_col;
        r.ch   = '0;
        r.attr = '0;
        if (w.kind == KIND_PUT)
        begin
            puts_done++;
            if (w.char_code == CHAR_NEWLINE)
            begin
                col = 0;
                row++;
            end
            else if (w.char_code == CHAR_TAB)
            begin
                if (col % TAB_WIDTH != 0)
                    col += TAB_WIDTH - col % TAB_WIDTH;
            end
            else if (w.char_code == CHAR_BACKSPACE)
            begin
                if (col > 0)
                    col--;
                else if (row > 0)
                begin
                    row--;
                    col = COLUMNS - 1;
                end
                shadow_store(row, col, CHAR_SPACE);
            end
            else
            begin
                shadow_store(row, col, w.char_code);
                col++;
            end
            if (col >= COLUMNS)
            begin
                wraps_done++;
                col = 0;
                row++;
            end
            if (row >= ROWS)
            begin
                scrolls_done++;
                for (int i = 0; i < CELLS - COLUMNS; i++)
                begin
                    shadow_chars[i] = shadow_chars[i + COLUMNS];
                    shadow_attrs[i] = shadow_attrs[i + COLUMNS];
                end
                for (int c = 0; c < COLUMNS; c++)
                    shadow_store(ROWS - 1, c, CHAR_SPACE);
                col = 0;
                row = ROWS - 1;
            end
            shadow_row = row;
            shadow_col = col;
        end
        else
        begin
            reads_done++;
            if (w.read_row < ROWS && w.read_col < COLUMNS)
            begin
                r.ch   = shadow_chars[w.read_row * COLUMNS + w.read_col];
                r.attr = shadow_attrs[w.read_row * COLUMNS + w.read_col];
            end
            else
                off_screen++;
        end
        r.row    = ROW_FIELD_W'(shadow_row);
        r.col    = COL_FIELD_W'(shadow_col);
        r.offset = OFFSET_FIELD_W'(shadow_row * COLUMNS + shadow_col);
        return r;
    endfunction

    // Mostly no idling, some short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_put(logic [BYTE_W-1:0] ch);
        console_word_t w;
        w.kind      = KIND_PUT;
        w.char_code = ch;
        w.read_row  = ROW_FIELD_W'($urandom);
        w.read_col  = COL_FIELD_W'($urandom);
        words_to_send.push_back(w);
    endfunction

    function automatic void queue_read(int row, int col);
        console_word_t w;
        w.kind      = KIND_READ;
        w.char_code = BYTE_W'($urandom);
        w.read_row  = ROW_FIELD_W'(row);
        w.read_col  = COL_FIELD_W'(col);
        words_to_send.push_back(w);
    endfunction

    function automatic console_word_t random_word(int newline_pct, int read_pct);
        console_word_t w;
        int            r;
        w.kind      = KIND_PUT;
        w.char_code = BYTE_W'($urandom);
        w.read_row  = ROW_FIELD_W'($urandom);
        w.read_col  = COL_FIELD_W'($urandom);
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < read_pct)
        begin
            w.kind = KIND_READ;
            // fresh text lands near the bottom once scrolling starts
            if (r < 50)
                w.read_row = ROW_FIELD_W'($urandom_range(ROWS - 5, ROWS - 1));
            else if (r < 85)
                w.read_row = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
            if (r < 85)
                w.read_col = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
        end
        else if (r < newline_pct)
            w.char_code = CHAR_NEWLINE;
        else if (r < newline_pct + 6)
            w.char_code = CHAR_TAB;
        else if (r < newline_pct + 12)
            w.char_code = CHAR_BACKSPACE;
        return w;
    endfunction

    function automatic void field_check(string field, logic [15:0] expected_value,
                                        logic [15:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $error("%s: expected %0d, actual %0d", field, expected_value, actual_value);
            failures++;
        end
    endfunction

    // Driver: offer queued words, hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken_word.kind      = kind;
                taken_word.char_code = char_code;
                taken_word.read_row  = read_row;
                taken_word.read_col  = read_col;
                awaited_results.push_back(console_apply(taken_word));
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() != 0)
                begin
                    next_word = words_to_send.pop_front();
                    kind      <= next_word.kind;
                    char_code <= next_word.char_code;
                    read_row  <= next_word.read_row;
                    read_col  <= next_word.read_col;
                    in_valid  <= 1'b1;
                    send_gap  = sender_gaps_on ? idle_length() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: take results, compare against the oldest expectation, drive stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result word: row %0d col %0d char %0d",
                           cursor_row, cursor_col, cell_char);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    field_check("cursor_row", want.row, cursor_row);
                    field_check("cursor_col", want.col, cursor_col);
                    field_check("cursor_offset", want.offset, cursor_offset);
                    field_check("cell_char", want.ch, cell_char);
                    field_check("cell_attr", want.attr, cell_attr);
                    results_checked++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_len = receiver_stalls_on ? idle_length() : 0;
                hold_left = (stall_len > 0) ? stall_len - 1 : 0;
                out_stall <= (stall_len > 0);
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_attribute(input logic [BYTE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] attr_value;
        int                newline_pct;
        int                read_pct;
        shadow_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, off-screen reads, control codes at the edges
        queue_read(0, 0);
        queue_read(ROWS - 1, COLUMNS - 1);
        queue_read(31, 127);
        queue_read(ROWS, 0);
        queue_read(0, COLUMNS);
        queue_put(CHAR_BACKSPACE);          // top-left: stay and blank
        queue_put(8'h41);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(CHAR_TAB);
        queue_put(CHAR_TAB);                // already on a stop
        queue_put(CHAR_BACKSPACE);
        queue_put(CHAR_NEWLINE);
        queue_put(CHAR_BACKSPACE);          // column 0 back to previous row
        queue_put(8'h5A);                   // last column, wraps
        queue_read(0, COLUMNS - 1);
        queue_read(0, 0);
        queue_read(0, 2);
        queue_read(0, 7);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    attr_value = 8'h00; newline_pct = 6; read_pct = 25;
                    sender_gaps_on = 1'b1; receiver_stalls_on = 1'b1;
                end
                1:
                begin
                    attr_value = 8'hFF; newline_pct = 6; read_pct = 25;
                    sender_gaps_on = 1'b0; receiver_stalls_on = 1'b0;
                end
                2:
                begin
                    attr_value = BYTE_W'($urandom); newline_pct = 30; read_pct = 20;
                    sender_gaps_on = 1'b1; receiver_stalls_on = 1'b1;
                end
                3:
                begin
                    attr_value = BYTE_W'($urandom); newline_pct = 6; read_pct = 50;
                    sender_gaps_on = 1'b1; receiver_stalls_on = 1'b0;
                end
                default:
                begin
                    attr_value = 8'h5A; newline_pct = 10; read_pct = 25;
                    sender_gaps_on = 1'b0; receiver_stalls_on = 1'b1;
                end
            endcase
            write_attribute(attr_value);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                words_to_send.push_back(random_word(newline_pct, read_pct));
            // back-pressure: receiver holds off while the sender keeps offering
            if (p == RANDOM_PHASES - 1)
                holds_asked++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Run covered %0d puts with %0d wraps and %0d scrolls, %0d reads (%0d off screen).",
                 puts_done, wraps_done, scrolls_done, reads_done, off_screen);
        $display("%0d results compared across %0d attribute settings.",
                 results_checked, attr_writes + 1);
        if (failures == 0)
            $display("tb_text_console_writer_top: PASS");
        else
            $display("tb_text_console_writer_top: FAIL");
        $finish;
    end

    // Watchdog: worst case is every word scrolling behind long stalls
    initial
    begin
        #(80_000_000);
        $display("tb_text_console_writer_top: FAIL");
        $finish;
    end

endmodule
